FILE: rtl/itoa_pkg.sv
// Shared types, codes and character table for the integer-to-ASCII converter.
package itoa_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Request codes
    localparam logic [1:0] REQ_SDEC  = 2'd0;
    localparam logic [1:0] REQ_UDEC  = 2'd1;
    localparam logic [1:0] REQ_HEX32 = 2'd2;
    localparam logic [1:0] REQ_HEX64 = 2'd3;

    localparam logic [7:0] ASCII_MINUS = 8'h2d;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // Classified job: magnitude plus how to print it
    typedef struct packed {
        logic        dec;
        logic        neg;
        logic [63:0] mag;
    } t_job;

    // Digits ready for output, least significant nibble at the bottom
    typedef struct packed {
        logic        neg;
        logic [3:0]  top;
        logic [63:0] nib;
    } t_digits;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

FILE: rtl/itoa_if.sv
// Valid/ready channel interfaces for the converter's input and output.
interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/itoa_front.sv
// Front end: accepts requests, takes the magnitude and sign, registers the job.
module itoa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    itoa_in_if.sink         i_in,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output itoa_pkg::t_job  o_job
);
    import itoa_pkg::*;

    logic        r_valid;
    t_job        r_job;
    t_job        n_job;
    logic [31:0] lo;

    assign lo = i_in.value[31:0];
    assign i_in.ready = !r_valid || i_job_ready;

    always_comb begin
        n_job.dec = 1'b1;
        n_job.neg = 1'b0;
        n_job.mag = {32'd0, lo};
        case (i_in.req_type)
            REQ_SDEC: begin
                n_job.neg = lo[31];
                if (lo[31]) begin
                    n_job.mag = {32'd0, 32'(~lo + 32'd1)};
                end
            end
            REQ_UDEC: begin
                n_job.dec = 1'b1;
            end
            REQ_HEX32: begin
                n_job.dec = 1'b0;
            end
            REQ_HEX64: begin
                n_job.dec = 1'b0;
                n_job.mag = i_in.value;
            end
            default: begin
                n_job.dec = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

FILE: rtl/itoa_queue.sv
// Short job queue between the front end and the converter.
module itoa_queue #(
    parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  itoa_pkg::t_job  i_wr_data,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output itoa_pkg::t_job  o_rd_data
);
    import itoa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign push = i_wr_valid && o_wr_ready;
    assign pop  = o_rd_valid && i_rd_ready;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/itoa_conv.sv
// Converter: binary to BCD by shift-and-add-3, four bits a cycle; hex passes.
module itoa_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  itoa_pkg::t_job    i_job,
    output logic              o_dig_valid,
    input  logic              i_dig_ready,
    output itoa_pkg::t_digits o_dig
);
    import itoa_pkg::*;

    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DABBLE = 3'b010,
        S_HOLD   = 3'b100
    } t_conv_state;

    t_conv_state        r_state;
    t_conv_state        n_state;
    logic [2:0]         r_step;
    logic               r_neg;
    logic [BCD_W+31:0]  r_work;
    logic [63:0]        r_nib;
    logic [BCD_W+31:0]  n_work;
    logic [3:0]         top;

    // One shift-and-add-3 step over the BCD digits and the binary tail
    function automatic logic [BCD_W+31:0] dabble(input logic [BCD_W+31:0] x);
        logic [BCD_W+31:0] y;
        y = x;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (y[32 + 4*d +: 4] >= 4'd5) begin
                y[32 + 4*d +: 4] = y[32 + 4*d +: 4] + 4'd3;
            end
        end
        return {y[BCD_W+30:0], 1'b0};
    endfunction

    always_comb begin
        n_work = r_work;
        for (int s = 0; s < 4; s++) begin
            n_work = dabble(n_work);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.dec ? S_DABBLE : S_HOLD;
                end
            end
            S_DABBLE: begin
                if (r_step == 3'd7) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_dig_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_step <= '0;
                r_neg  <= i_job.neg;
                r_work <= {{BCD_W{1'b0}}, i_job.mag[31:0]};
                r_nib  <= i_job.mag;
            end
            S_DABBLE: begin
                r_step <= r_step + 3'd1;
                r_work <= n_work;
                if (r_step == 3'd7) begin
                    r_nib <= {{(64 - BCD_W){1'b0}}, n_work[BCD_W+31:32]};
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Highest nonzero nibble; zero prints as a single digit
    always_comb begin
        top = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (r_nib[4*i +: 4] != 4'd0) begin
                top = 4'(i);
            end
        end
    end

    assign o_job_ready = (r_state == S_IDLE);
    assign o_dig_valid = (r_state == S_HOLD);
    assign o_dig.neg   = r_neg;
    assign o_dig.top   = top;
    assign o_dig.nib   = r_nib;

endmodule

FILE: rtl/itoa_emit.sv
// Output stage: sends the sign, then digits most significant first.
module itoa_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_dig_valid,
    output logic              o_dig_ready,
    input  itoa_pkg::t_digits i_dig,
    itoa_out_if.source        o_out
);
    import itoa_pkg::*;

    logic        r_valid;
    logic        r_neg_pend;
    logic [3:0]  r_idx;
    logic [63:0] r_nib;
    logic        last;
    logic        xfer;

    assign last = !r_neg_pend && (r_idx == 4'd0);
    assign xfer = r_valid && o_out.ready;
    assign o_dig_ready = !r_valid || (xfer && last);

    assign o_out.valid     = r_valid;
    assign o_out.last_char = last;
    assign o_out.char_code = r_neg_pend ? ASCII_MINUS
                                        : digit_char(r_nib[{r_idx, 2'b00} +: 4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_dig_ready) begin
            r_valid <= i_dig_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_dig_ready && i_dig_valid) begin
            r_neg_pend <= i_dig.neg;
            r_idx      <= i_dig.top;
            r_nib      <= i_dig.nib;
        end else if (xfer) begin
            // drop the sign first, then walk down the digits
            if (r_neg_pend) begin
                r_neg_pend <= 1'b0;
            end else if (r_idx != 4'd0) begin
                r_idx <= r_idx - 4'd1;
            end
        end
    end

endmodule

FILE: rtl/integer_to_ascii_converter.sv
// Top level of the integer-to-ASCII converter.
//
// Each input transaction carries a request type and a 64-bit value; the block
// returns the value's text one character per output transaction, most
// significant first, with last_char set on the final one. Modes: signed
// decimal (low 32 bits, leading '-'), unsigned decimal (low 32 bits), hex of
// the low 32 bits, hex of all 64 bits; lowercase, no leading zeros, no NUL.
// Requests are registered and queued, then converted while the previous
// number is still being sent. Decimal conversion runs a load, eight
// shift-and-add-3 steps at four bits each and a handoff; hex runs a load
// and a handoff. Output runs at one character per cycle while o_out.ready
// holds, and a hex text has 1 to 16 characters, so the output stage's
// character rate bounds long hex values.
module integer_to_ascii_converter #(
    parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);
    import itoa_pkg::*;

    logic    front_valid;
    logic    front_ready;
    t_job    front_job;
    logic    q_valid;
    logic    q_ready;
    t_job    q_job;
    logic    dig_valid;
    logic    dig_ready;
    t_digits dig;

    itoa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    itoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_data  (front_job),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_job)
    );

    itoa_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_dig_valid (dig_valid),
        .i_dig_ready (dig_ready),
        .o_dig       (dig)
    );

    itoa_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dig_valid (dig_valid),
        .o_dig_ready (dig_ready),
        .i_dig       (dig),
        .o_out       (o_out)
    );

endmodule
